// ----- rtl/nsgp_pkg.sv -----
// ----------------------------------------------------------------------------
// nsgp_pkg
// shared types and constants for the mono note stack gate/pitch block
// ----------------------------------------------------------------------------
package nsgp_pkg;

   // note stack geometry
   localparam int STACK_DEPTH = 8;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

   // field widths
   localparam int MODE_W  = 2;
   localparam int NOTE_W  = 7;
   localparam int HIGH_W  = 8;
   localparam int STEP_W  = 16;
   localparam int PULSE_W = 20;
   localparam int TIME_W  = 32;
   localparam int PITCH_W = 12;
   localparam int PROD_W  = NOTE_W + STEP_W;
   localparam int FRAC_W  = 8;

   localparam logic [PITCH_W-1:0] PITCH_MAX = {PITCH_W{1'b1}};
   localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(128);

   // item kinds
   localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

   // register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] REG_LOWEST_NOTE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHEST_NOTE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_MODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RETRIG_PULSE = 3'd4;

   // register reset values
   localparam logic [NOTE_W-1:0]  LOWEST_RST  = 7'd36;
   localparam logic [HIGH_W-1:0]  HIGHEST_RST = 8'd92;
   localparam logic [STEP_W-1:0]  STEP_RST    = 16'd21760;
   localparam logic [PULSE_W-1:0] PULSE_RST   = 20'd10000;

   // input word
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [NOTE_W-1:0] note;
      logic [TIME_W-1:0] time_us;
   } req_word_type;

   // result word
   typedef struct packed {
      logic               gate;
      logic [PITCH_W-1:0] pitch;
      logic               pitch_updated;
   } rsp_word_type;

   // stack engine command
   typedef struct packed {
      logic              start;
      logic [NOTE_W-1:0] off;
      logic              push;
   } stack_cmd_type;

   // stack engine status
   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] count;
   } stack_sts_type;

endpackage

// ----- rtl/mono_note_stack_gate_pitch.sv -----
// ----------------------------------------------------------------------------
// mono_note_stack_gate_pitch
// monophonic last-note-priority note stack driving gate and pitch dac codes
// ----------------------------------------------------------------------------
// usage:
//   start/busy input channel takes one word (note on, note off or tick) when
//   start is high and busy is low. busy stays high until the result is out.
//   every word gives exactly one result: rsp_valid strobes for one cycle with
//   gate, pitch and pitch_updated. the receiver cannot stall, so the result
//   register is simply overwritten by the next word's result.
//   the csr write channel (csr_valid/csr_ready, always ready) sets lowest
//   note, highest note, trigger mode, pitch step and retrigger pulse length;
//   write only while busy is low.
// sequencing:
//   every word passes decode and finish, and the next word can be accepted
//   once the result is out. ticks, mode 3 and words that skip the stack
//   go from decode straight to finish. a note off walks the ram-held stack
//   one entry a cycle; a note on walks it too, then appends its note; a
//   full stack first sheds its oldest entry in a second walk. the engine's single ram port pair paces each walk.
// reset:
//   synchronous; registers return to defaults, stack empty, gate low,
//   pitch zero. no ram clearing pass is needed.
// ----------------------------------------------------------------------------
module mono_note_stack_gate_pitch (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  nsgp_pkg::req_word_type                req_item,
   output logic                                  rsp_valid,
   output nsgp_pkg::rsp_word_type                rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nsgp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nsgp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // configuration registers
   logic [nsgp_pkg::NOTE_W-1:0]  lowest_ff;
   logic [nsgp_pkg::HIGH_W-1:0]  highest_ff;
   logic                         trig_ff;
   logic [nsgp_pkg::STEP_W-1:0]  step_ff;
   logic [nsgp_pkg::PULSE_W-1:0] pulse_len_ff;

   // control and voice state
   logic [1:0]                   state_ff, state_in;
   logic                         gate_ff, gate_in;
   logic [nsgp_pkg::PITCH_W-1:0] pitch_ff, pitch_in;
   logic                         pending_ff, pending_in;
   logic [nsgp_pkg::TIME_W-1:0]  start_time_ff, start_time_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // item payload
   nsgp_pkg::req_word_type       item_ff;
   logic                         hit_ff;
   logic                         was_held_ff;
   logic [nsgp_pkg::PROD_W-1:0]  prod_ff;
   nsgp_pkg::rsp_word_type       rsp_item_ff, rsp_item_in;

   nsgp_pkg::stack_cmd_type      eng_cmd;
   nsgp_pkg::stack_sts_type      eng_sts;

   logic                         accept;
   logic                         hit;
   logic [nsgp_pkg::NOTE_W-1:0]  off;
   logic                         need_stack;
   logic [nsgp_pkg::PROD_W:0]    rounded;
   logic [nsgp_pkg::STEP_W-1:0]  pitch_raw;
   logic [nsgp_pkg::PITCH_W-1:0] pitch_sat;
   logic [nsgp_pkg::TIME_W-1:0]  elapsed;
   logic                         pulse_over;
   logic                         updated;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // range check and offset of the held item
   assign hit = ({1'b0, item_ff.note} >= {1'b0, lowest_ff})
                && ({1'b0, item_ff.note} < highest_ff);
   assign off = item_ff.note - lowest_ff;
   assign need_stack = hit && ((item_ff.mode == nsgp_pkg::MODE_NOTE_ON)
                || ((item_ff.mode == nsgp_pkg::MODE_NOTE_OFF) && (eng_sts.count != '0)));

   assign eng_cmd.start = (state_ff == S_DECODE) && need_stack;
   assign eng_cmd.off   = off;
   assign eng_cmd.push  = (item_ff.mode == nsgp_pkg::MODE_NOTE_ON);

   nsgp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .sts   (eng_sts)
   );

   // pitch rounding half up and saturation
   assign rounded   = {1'b0, prod_ff} + nsgp_pkg::ROUND_HALF;
   assign pitch_raw = rounded[nsgp_pkg::PROD_W:nsgp_pkg::FRAC_W];
   assign pitch_sat = (pitch_raw > {4'b0, nsgp_pkg::PITCH_MAX}) ? nsgp_pkg::PITCH_MAX
                      : pitch_raw[nsgp_pkg::PITCH_W-1:0];

   // retrigger pulse timing, modular
   assign elapsed    = item_ff.time_us - start_time_ff;
   assign pulse_over = elapsed >= {12'b0, pulse_len_ff};

   // sequencer and voice update
   always_comb begin
      state_in      = state_ff;
      gate_in       = gate_ff;
      pitch_in      = pitch_ff;
      pending_in    = pending_ff;
      start_time_in = start_time_ff;
      rsp_valid_in  = 1'b0;
      updated       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = need_stack ? S_WAIT : S_FINISH;
         end
         S_WAIT: begin
            if (eng_sts.done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (item_ff.mode)
               nsgp_pkg::MODE_NOTE_ON: begin
                  if (hit_ff) begin
                     updated  = 1'b1;
                     pitch_in = pitch_sat;
                     if (trig_ff && was_held_ff) begin
                        pending_in    = 1'b1;
                        gate_in       = 1'b0;
                        start_time_in = item_ff.time_us;
                     end else begin
                        gate_in = 1'b1;
                     end
                  end
               end
               nsgp_pkg::MODE_NOTE_OFF: begin
                  if (hit_ff && (eng_sts.count == '0)) begin
                     pending_in = 1'b0;
                     gate_in    = 1'b0;
                  end
               end
               nsgp_pkg::MODE_TICK: begin
                  if ((eng_sts.count != '0) && pending_ff && pulse_over) begin
                     pending_in = 1'b0;
                     gate_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result word
   always_comb begin
      rsp_item_in.gate          = gate_in;
      rsp_item_in.pitch         = pitch_in;
      rsp_item_in.pitch_updated = updated;
   end

   // control and voice registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gate_ff       <= 1'b0;
         pitch_ff      <= '0;
         pending_ff    <= 1'b0;
         start_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gate_ff       <= gate_in;
         pitch_ff      <= pitch_in;
         pending_ff    <= pending_in;
         start_time_ff <= start_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (state_ff == S_DECODE) begin
         hit_ff      <= hit;
         was_held_ff <= (eng_sts.count != '0);
         prod_ff     <= nsgp_pkg::PROD_W'(off) * nsgp_pkg::PROD_W'(step_ff);
      end
      if (state_ff == S_FINISH) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff    <= nsgp_pkg::LOWEST_RST;
         highest_ff   <= nsgp_pkg::HIGHEST_RST;
         trig_ff      <= 1'b0;
         step_ff      <= nsgp_pkg::STEP_RST;
         pulse_len_ff <= nsgp_pkg::PULSE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            nsgp_pkg::REG_LOWEST_NOTE:  lowest_ff    <= csr_wdata[nsgp_pkg::NOTE_W-1:0];
            nsgp_pkg::REG_HIGHEST_NOTE: highest_ff   <= csr_wdata[nsgp_pkg::HIGH_W-1:0];
            nsgp_pkg::REG_TRIGGER_MODE: trig_ff      <= csr_wdata[0];
            nsgp_pkg::REG_PITCH_STEP:   step_ff      <= csr_wdata[nsgp_pkg::STEP_W-1:0];
            nsgp_pkg::REG_RETRIG_PULSE: pulse_len_ff <= csr_wdata[nsgp_pkg::PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_FINISH))
      else $error("result strobe without a finished word");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |-> (state_ff == S_WAIT))
      else $error("stack engine finished outside wait state");
   a_updated_note_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.pitch_updated) |-> (item_ff.mode == nsgp_pkg::MODE_NOTE_ON))
      else $error("pitch updated by a word that is not a note on");
`endif

endmodule

// ----- rtl/nsgp_stack_ram.sv -----
// ----------------------------------------------------------------------------
// nsgp_stack_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nsgp_stack_ram #(
   parameter int DEPTH  = 8,
   parameter int WIDTH  = 7,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/nsgp_stack.sv -----
// ----------------------------------------------------------------------------
// nsgp_stack
// note stack engine: compacts the stack in ram one entry per cycle,
// drops the oldest entry when full and nothing matched, then appends the new note
// ----------------------------------------------------------------------------
module nsgp_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  nsgp_pkg::stack_cmd_type cmd,
   output nsgp_pkg::stack_sts_type sts
);

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_WALK = 2'd1;
   localparam logic [1:0] E_PUSH = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [nsgp_pkg::CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [nsgp_pkg::CNT_W-1:0]     wr_idx_ff, wr_idx_in;
   logic [nsgp_pkg::CNT_W-1:0]     len_ff, len_in;
   logic [nsgp_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [nsgp_pkg::NOTE_W-1:0]    off_ff, off_in;
   logic                           push_ff, push_in;
   logic                           match_ff, match_in;
   logic                           drop_first_ff, drop_first_in;
   logic                           rd_vld_ff, rd_first_ff;
   logic                           done_ff, done_in;

   logic                           rd_en, keep, wr_en, pass_end;
   logic [nsgp_pkg::NOTE_W-1:0]    rd_data, wr_data;

   // read side walks ahead, write side trails by at least one entry
   assign rd_en    = (state_ff == E_WALK) && (rd_idx_ff < len_ff);
   assign keep     = rd_vld_ff && !(match_ff && (rd_data == off_ff))
                     && !(drop_first_ff && rd_first_ff);
   assign wr_en    = ((state_ff == E_WALK) && keep) || (state_ff == E_PUSH);
   assign wr_data  = (state_ff == E_PUSH) ? off_ff : rd_data;
   assign pass_end = (state_ff == E_WALK) && !rd_en && !rd_vld_ff;

   nsgp_stack_ram #(
      .DEPTH  (nsgp_pkg::STACK_DEPTH),
      .WIDTH  (nsgp_pkg::NOTE_W),
      .ADDR_W (nsgp_pkg::IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ff[nsgp_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[nsgp_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      len_in        = len_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      push_in       = push_ff;
      match_in      = match_ff;
      drop_first_in = drop_first_ff;
      done_in       = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               state_in      = E_WALK;
               rd_idx_in     = '0;
               wr_idx_in     = '0;
               len_in        = count_ff;
               off_in        = cmd.off;
               push_in       = cmd.push;
               match_in      = 1'b1;
               drop_first_in = 1'b0;
            end
         end
         E_WALK: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + nsgp_pkg::CNT_W'(1);
            end
            if (keep) begin
               wr_idx_in = wr_idx_ff + nsgp_pkg::CNT_W'(1);
            end
            if (pass_end) begin
               if (match_ff && push_ff && (wr_idx_ff == nsgp_pkg::DEPTH_CNT)) begin
                  // full and nothing removed: shift out the oldest entry
                  rd_idx_in     = '0;
                  wr_idx_in     = '0;
                  len_in        = nsgp_pkg::DEPTH_CNT;
                  match_in      = 1'b0;
                  drop_first_in = 1'b1;
               end else if (push_ff) begin
                  state_in = E_PUSH;
               end else begin
                  count_in = wr_idx_ff;
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end
         end
         E_PUSH: begin
            count_in = wr_idx_ff + nsgp_pkg::CNT_W'(1);
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= E_IDLE;
         count_ff  <= '0;
         done_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
         rd_vld_ff <= rd_en;
      end
   end

   // pass registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      len_ff        <= len_in;
      off_ff        <= off_in;
      push_ff       <= push_in;
      match_ff      <= match_in;
      drop_first_ff <= drop_first_in;
      rd_first_ff   <= (rd_idx_ff == '0);
   end

   assign sts.done  = done_ff;
   assign sts.count = count_ff;

`ifndef SYNTHESIS
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_idx_ff != wr_idx_ff))
      else $error("stack read and write hit the same entry");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nsgp_pkg::DEPTH_CNT)
      else $error("stack count beyond depth");
   a_write_trails: assert property (@(posedge clock) disable iff (reset)
      (state_ff == E_WALK) |-> (wr_idx_ff <= rd_idx_ff))
      else $error("stack write index ahead of read index");
`endif

endmodule
